// File: rtl/core/mfb_pkg.sv
// Shared types, constants and mask helpers for the monochrome frame store fill unit.
// No dependencies; every other file in rtl/core except mfb_ram imports this package.
`default_nettype none

package mfb_pkg;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 132;
    localparam int SCREEN_HEIGHT_DEF = 64;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 8;
    localparam int INDEX_W = 11;
    localparam int DATA_W  = 8;
    // Pixel positions up to 256x256 and byte bases fit here
    localparam int POS_W   = 16;

    localparam int QUEUE_DEPTH = 2;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Layout register values
    localparam logic LAYOUT_LINEAR = 1'b0;
    localparam logic LAYOUT_PAGE   = 1'b1;

    localparam logic [DATA_W-1:0] CLEAR_BYTE_LINEAR = 8'h00;
    localparam logic [DATA_W-1:0] CLEAR_BYTE_PAGE   = 8'hFF;
    localparam logic [DATA_W-1:0] BYTE_ALL_ONES     = 8'hFF;
    localparam logic [2:0]        BIT_LAST          = 3'd7;

    // Work classified by the front end
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_FILL,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] col_first;
        logic [COORD_W-1:0] col_last;   // clipped
        logic [COORD_W-1:0] line_first; // row (linear) or page (page layout)
        logic [COORD_W-1:0] line_last;
        logic [2:0]         row_lo;     // bit range inside first/last page
        logic [2:0]         row_hi;
        logic [POS_W-1:0]   base;       // first line base, or byte index for a read
    } desc_t;

    // Bits lo..hi counted from the MSB
    function automatic logic [DATA_W-1:0] msb_mask(input logic [2:0] lo, input logic [2:0] hi);
        msb_mask = (BYTE_ALL_ONES >> lo) & (BYTE_ALL_ONES << (BIT_LAST - hi));
    endfunction

    // Bits lo..hi counted from the LSB
    function automatic logic [DATA_W-1:0] lsb_mask(input logic [2:0] lo, input logic [2:0] hi);
        lsb_mask = (BYTE_ALL_ONES << lo) & (BYTE_ALL_ONES >> (BIT_LAST - hi));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mfb_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mfb_pkg for field widths.
`default_nettype none

interface mfb_cmd_if;
    import mfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;
    logic [INDEX_W-1:0] byte_index;

    modport source (
        output valid, command, row_first, col_first, row_last, col_last, byte_index,
        input  ready
    );
    modport sink (
        input  valid, command, row_first, col_first, row_last, col_last, byte_index,
        output ready
    );
endinterface

interface mfb_result_if;
    import mfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mfb_ram.sv
// Generic single-port RAM with registered read data.
// No package dependencies.
`default_nettype none

module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1056
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/mfb_queue.sv
// Short descriptor queue between the front end and the back end.
// Depends on mfb_pkg for desc_t.
`default_nettype none

module mfb_queue #(
    parameter int DEPTH = mfb_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mfb_pkg::desc_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output mfb_pkg::desc_t      pop_data
);
    import mfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mfb_front.sv
// Front end: takes command transfers, clips and classifies them into descriptors.
// Depends on mfb_pkg and mfb_if.
`default_nettype none

module mfb_front #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF,
    parameter int LINEAR_BYTES  = 1056,
    parameter int PAGE_BYTES    = 1056
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      layout_mode,
    mfb_cmd_if.sink        cmd,
    output logic           push_valid,
    input  wire logic      push_ready,
    output mfb_pkg::desc_t push_data
);
    import mfb_pkg::*;

    localparam logic [COORD_W:0]   WIDTH_K  = (COORD_W + 1)'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0] ROW_MAX  = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [COORD_W-1:0] COL_MAX  = COORD_W'(SCREEN_WIDTH - 1);
    localparam int                 PROD_W   = 2 * COORD_W + 1;

    logic               stage_valid_reg;
    desc_t              stage_reg;
    desc_t              desc_next;
    logic [COORD_W-1:0] row_last_clip;
    logic [COORD_W-1:0] col_last_clip;
    logic [COORD_W-1:0] mul_arg;
    logic [PROD_W-1:0]  product;
    logic               empty_rect;
    logic               read_ok;
    logic               take;

    assign cmd.ready  = !stage_valid_reg || push_ready;
    assign take       = cmd.valid && cmd.ready;
    assign push_valid = stage_valid_reg;
    assign push_data  = stage_reg;

    always_comb
    begin
        row_last_clip = (cmd.row_last > ROW_MAX) ? ROW_MAX : cmd.row_last;
        col_last_clip = (cmd.col_last > COL_MAX) ? COL_MAX : cmd.col_last;
        empty_rect    = (cmd.row_first > row_last_clip) || (cmd.col_first > col_last_clip);
        // line base: row * width positions, or page * width bytes
        mul_arg = (layout_mode == LAYOUT_PAGE) ? (cmd.row_first >> 3) : cmd.row_first;
        product = PROD_W'(mul_arg) * PROD_W'(WIDTH_K);
        if (layout_mode == LAYOUT_PAGE)
        begin
            read_ok = (POS_W'(cmd.byte_index) < POS_W'(PAGE_BYTES));
        end
        else
        begin
            read_ok = (POS_W'(cmd.byte_index) < POS_W'(LINEAR_BYTES));
        end

        desc_next.col_first = cmd.col_first;
        desc_next.col_last  = col_last_clip;
        desc_next.row_lo    = cmd.row_first[2:0];
        desc_next.row_hi    = row_last_clip[2:0];
        if (layout_mode == LAYOUT_PAGE)
        begin
            desc_next.line_first = cmd.row_first >> 3;
            desc_next.line_last  = row_last_clip >> 3;
        end
        else
        begin
            desc_next.line_first = cmd.row_first;
            desc_next.line_last  = row_last_clip;
        end
        desc_next.base = product[POS_W-1:0];

        case (cmd.command)
            CMD_CLEAR: desc_next.op = OP_CLEAR;
            CMD_FILL:  desc_next.op = empty_rect ? OP_NOP : OP_FILL;
            CMD_READ:
            begin
                desc_next.op   = read_ok ? OP_READ : OP_NOP;
                desc_next.base = POS_W'(cmd.byte_index);
            end
            default:   desc_next.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= desc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mfb_back.sv
// Back end: sweeps and read-modify-writes the frame store, returns one result per command.
// Depends on mfb_pkg, mfb_if and mfb_ram.
`default_nettype none

module mfb_back #(
    parameter int SCREEN_WIDTH = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int STORE_BYTES  = 1056
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           layout_mode,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire mfb_pkg::desc_t pop_data,
    mfb_result_if.source        result
);
    import mfb_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);

    typedef enum logic [3:0] {
        S_INIT,     // zeroing pass after reset
        S_IDLE,
        S_CLEAR,
        S_LINE,
        S_RD,
        S_WR,
        S_RRD,
        S_RCAP,
        S_DONE
    } state_t;

    state_t             state_reg;
    desc_t              desc_reg;
    logic [ADDR_W-1:0]  cur_reg;
    logic [COORD_W-1:0] line_reg;
    logic [POS_W-1:0]   base_reg;
    logic [DATA_W-1:0]  fill_reg;
    logic [DATA_W-1:0]  result_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;

    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic [ADDR_W-1:0]  first_byte;
    logic [ADDR_W-1:0]  last_byte;
    logic [2:0]         bit_lo;
    logic [2:0]         bit_hi;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  new_byte;
    logic               ram_we;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;
    logic               page_mode;

    assign page_mode      = (layout_mode == LAYOUT_PAGE);
    assign pop_ready      = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.read_data = out_data_reg;

    always_comb
    begin
        start_pos = base_reg + POS_W'(desc_reg.col_first);
        end_pos   = base_reg + POS_W'(desc_reg.col_last);
        if (page_mode)
        begin
            first_byte = ADDR_W'(start_pos);
            last_byte  = ADDR_W'(end_pos);
            bit_lo     = (line_reg == desc_reg.line_first) ? desc_reg.row_lo : 3'd0;
            bit_hi     = (line_reg == desc_reg.line_last) ? desc_reg.row_hi : BIT_LAST;
            mask       = lsb_mask(bit_lo, bit_hi);
            new_byte   = ram_rdata & ~mask;
        end
        else
        begin
            first_byte = ADDR_W'(start_pos >> 3);
            last_byte  = ADDR_W'(end_pos >> 3);
            bit_lo     = (cur_reg == first_byte) ? start_pos[2:0] : 3'd0;
            bit_hi     = (cur_reg == last_byte) ? end_pos[2:0] : BIT_LAST;
            mask       = msb_mask(bit_lo, bit_hi);
            new_byte   = ram_rdata | mask;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = CLEAR_BYTE_LINEAR;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = fill_reg;
            end
            S_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = new_byte;
            end
            default:
            begin
                ram_we    = 1'b0;
                ram_wdata = new_byte;
            end
        endcase
    end

    mfb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (cur_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            desc_reg      <= '0;
            line_reg      <= '0;
            base_reg      <= '0;
            fill_reg      <= '0;
            result_reg    <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // a finished command loads the output register once it is free
            if (state_reg == S_DONE && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_INIT:
                begin
                    if (cur_reg == ADDR_W'(STORE_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        desc_reg   <= pop_data;
                        line_reg   <= pop_data.line_first;
                        base_reg   <= pop_data.base;
                        result_reg <= '0;
                        case (pop_data.op)
                            OP_CLEAR:
                            begin
                                cur_reg   <= '0;
                                fill_reg  <= page_mode ? CLEAR_BYTE_PAGE : CLEAR_BYTE_LINEAR;
                                state_reg <= S_CLEAR;
                            end
                            OP_FILL:
                            begin
                                state_reg <= S_LINE;
                            end
                            OP_READ:
                            begin
                                cur_reg   <= ADDR_W'(pop_data.base);
                                state_reg <= S_RRD;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    if (cur_reg == ADDR_W'(STORE_BYTES - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + 1'b1;
                    end
                end
                S_LINE:
                begin
                    cur_reg   <= first_byte;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (cur_reg == last_byte)
                    begin
                        if (line_reg == desc_reg.line_last)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // next row (linear) or page: both advance by one screen width
                            line_reg  <= line_reg + 1'b1;
                            base_reg  <= base_reg + POS_W'(SCREEN_WIDTH);
                            state_reg <= S_LINE;
                        end
                    end
                    else
                    begin
                        cur_reg   <= cur_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_RRD:
                begin
                    state_reg <= S_RCAP;
                end
                S_RCAP:
                begin
                    result_reg <= ram_rdata;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_data_reg  <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mono_framebuffer_rect_fill_unit.sv
// Monochrome frame store with clear, rectangle fill and byte read-back. Commands are
// taken by a front end that clips rectangles to the screen and classifies them, then
// wait in a two-entry queue for the back end, which owns the single byte-wide store
// port. Every command returns exactly one result, in order (read_data is zero except
// for an in-range read). All work goes through that one store port: a clear writes
// every store byte, a fill reads and then writes each store byte touched, with a line
// step per row (linear layout) or per page (page layout). After reset the back end
// zeroes the store, one byte a cycle, before its first command; the front end still
// takes up to three commands meanwhile. layout_mode must be written through
// cfg_we/cfg_wdata only while the unit is idle; the unit does not enforce this.
// Depends on mfb_pkg, mfb_if, mfb_front, mfb_queue and mfb_back.
`default_nettype none

module mono_framebuffer_rect_fill_unit #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mfb_cmd_if.sink      cmd,
    mfb_result_if.source result,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata
);
    import mfb_pkg::*;

    localparam int LINEAR_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
    localparam int PAGE_BYTES   = ((SCREEN_HEIGHT + 7) / 8) * SCREEN_WIDTH;
    localparam int STORE_BYTES  = (LINEAR_BYTES > PAGE_BYTES) ? LINEAR_BYTES : PAGE_BYTES;

    logic  layout_mode_reg;
    logic  push_valid;
    logic  push_ready;
    desc_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    desc_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_mode_reg <= LAYOUT_LINEAR;
        end
        else if (cfg_we)
        begin
            layout_mode_reg <= cfg_wdata;
        end
    end

    mfb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .LINEAR_BYTES  (LINEAR_BYTES),
        .PAGE_BYTES    (PAGE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .layout_mode (layout_mode_reg),
        .cmd         (cmd),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    mfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mfb_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .STORE_BYTES  (STORE_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .layout_mode (layout_mode_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .result      (result)
    );

endmodule

`default_nettype wire

// File: bench/fill_checker.sv
// Scoreboard for the frame store fill unit: watches the command, result and layout ports,
// keeps its own image of the store and compares every returned byte in order.
// Depends on mfb_pkg and the channel interfaces in mfb_if.
module fill_checker #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mfb_cmd_if        cmd_mon,
    mfb_result_if     res_mon,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    output int        errors,
    output int        outstanding,
    output int        results_checked
);
    import mfb_pkg::*;

    localparam int LINEAR_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
    localparam int PAGE_BYTES   = ((SCREEN_HEIGHT + 7) / 8) * SCREEN_WIDTH;
    localparam int IMAGE_BYTES  = (LINEAR_BYTES > PAGE_BYTES) ? LINEAR_BYTES : PAGE_BYTES;

    logic [DATA_W-1:0] image_bytes [IMAGE_BYTES];
    logic              layout_sel;
    logic [DATA_W-1:0] pending_bytes [$];

    // Updates the image for one command and returns the byte it should produce
    function automatic logic [DATA_W-1:0] apply_command(
        input logic [CMD_W-1:0]   code,
        input logic [COORD_W-1:0] r0,
        input logic [COORD_W-1:0] c0,
        input logic [COORD_W-1:0] r1,
        input logic [COORD_W-1:0] c1,
        input logic [INDEX_W-1:0] idx
    );
        int                row_end;
        int                col_end;
        int                pos;
        int                slot;
        int                limit;
        logic [DATA_W-1:0] rd;
        rd = '0;
        case (code)
            CMD_CLEAR:
            begin
                for (int i = 0; i < IMAGE_BYTES; i++)
                begin
                    image_bytes[i] = (layout_sel == LAYOUT_PAGE) ? CLEAR_BYTE_PAGE
                                                                 : CLEAR_BYTE_LINEAR;
                end
            end
            CMD_FILL:
            begin
                // only the far corner is clipped; a first corner off screen empties the loop
                row_end = (r1 > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : int'(r1);
                col_end = (c1 > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : int'(c1);
                for (int r = r0; r <= row_end; r++)
                begin
                    for (int c = c0; c <= col_end; c++)
                    begin
                        if (layout_sel == LAYOUT_LINEAR)
                        begin
                            pos  = r * SCREEN_WIDTH + c;
                            slot = pos >> 3;
                            if (slot < IMAGE_BYTES)
                                image_bytes[slot] |= 8'h80 >> (pos & 7);
                        end
                        else
                        begin
                            slot = (r >> 3) * SCREEN_WIDTH + c;
                            if (slot < IMAGE_BYTES)
                                image_bytes[slot] &= ~(8'h01 << (r & 7));
                        end
                    end
                end
            end
            CMD_READ:
            begin
                limit = (layout_sel == LAYOUT_PAGE) ? PAGE_BYTES : LINEAR_BYTES;
                if (idx < limit && idx < IMAGE_BYTES)
                    rd = image_bytes[idx];
            end
            default:
            begin
            end
        endcase
        return rd;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        errors = errors + 1;
        $display("[%0t] mismatch: %s: expected %02h, got %02h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < IMAGE_BYTES; i++)
            begin
                image_bytes[i] = '0;
            end
            layout_sel = LAYOUT_LINEAR;
            pending_bytes.delete();
            errors          = 0;
            results_checked = 0;
            outstanding    <= 0;
        end
        else
        begin
            // results first: a result never belongs to a command taken at the same edge
            if (res_mon.valid && res_mon.ready)
            begin
                results_checked = results_checked + 1;
                if (pending_bytes.size() == 0)
                    flag_mismatch("read_data with no command outstanding", '0,
                                  res_mon.read_data);
                else if (res_mon.read_data !== pending_bytes[0])
                begin
                    flag_mismatch("read_data", pending_bytes[0], res_mon.read_data);
                    void'(pending_bytes.pop_front());
                end
                else
                    void'(pending_bytes.pop_front());
            end
            if (cfg_we)
                layout_sel = cfg_wdata;
            if (cmd_mon.valid && cmd_mon.ready)
                pending_bytes.push_back(apply_command(cmd_mon.command, cmd_mon.row_first,
                                                      cmd_mon.col_first, cmd_mon.row_last,
                                                      cmd_mon.col_last, cmd_mon.byte_index));
            outstanding <= pending_bytes.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// Top of the frame store fill unit bench: clock, reset, layout writes, command stimulus
// and result back-pressure, with the verdict taken from fill_checker.
// Depends on mfb_pkg, mfb_if, the unit under test and fill_checker.
module tb_top;
    import mfb_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 9;
    localparam int PHASES           = 4;
    localparam int RANDOM_PER_PHASE = 131;
    localparam int MAX_WAIT         = 12;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RUN_LIMIT        = 50_000_000;
    localparam int SCREEN_W         = SCREEN_WIDTH_DEF;
    localparam int SCREEN_H         = SCREEN_HEIGHT_DEF;
    localparam int STORE_BYTES      = (SCREEN_W * SCREEN_H + 7) / 8;

    // code with no defined operation
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    int   fail_count;
    int   in_flight;
    int   results_seen;

    logic layout_now;
    bit   send_burst;
    bit   take_burst;
    int   hot_row;
    int   hot_col;
    int   n_clear;
    int   n_fill;
    int   n_read;
    int   n_spare;

    mfb_cmd_if    cmd_ch ();
    mfb_result_if res_ch ();

    mono_framebuffer_rect_fill_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    fill_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_mon         (cmd_ch),
        .res_mon         (res_ch),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .errors          (fail_count),
        .outstanding     (in_flight),
        .results_checked (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    task automatic send_cmd(input logic [CMD_W-1:0] code, input int r0, input int c0,
                            input int r1, input int c1, input int bidx);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= code;
        cmd_ch.row_first  <= r0[COORD_W-1:0];
        cmd_ch.col_first  <= c0[COORD_W-1:0];
        cmd_ch.row_last   <= r1[COORD_W-1:0];
        cmd_ch.col_last   <= c1[COORD_W-1:0];
        cmd_ch.byte_index <= bidx[INDEX_W-1:0];
        case (code)
            CMD_CLEAR: n_clear++;
            CMD_FILL:  n_fill++;
            CMD_READ:  n_read++;
            default:   n_spare++;
        endcase
        do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    // Drops valid and waits until every result is back
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_layout(input logic mode);
        cfg_we     <= 1'b1;
        cfg_wdata  <= mode;
        layout_now  = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_items();
        send_cmd(CMD_READ, 0, 0, 0, 0, 2047);
        send_cmd(CMD_FILL, 0, 0, 0, 0, 0);
        send_cmd(CMD_FILL, SCREEN_H - 1, SCREEN_W - 1, SCREEN_H - 1, SCREEN_W - 1, 0);
        send_cmd(CMD_FILL, 255, 255, 255, 255, 2047);
        send_cmd(CMD_FILL, 10, 5, 9, 20, 0);
        send_cmd(CMD_FILL, 5, 30, 20, 29, 0);
        send_cmd(CMD_SPARE, 255, 255, 255, 255, 2047);
        send_cmd(CMD_READ, 0, 0, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0, STORE_BYTES - 1);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
        // crosses a page boundary and several byte boundaries
        send_cmd(CMD_FILL, 5, 7, 13, 40, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0, 83);
        send_cmd(CMD_READ, 0, 0, 0, 0, SCREEN_W + 7);
    endtask

    task automatic random_item();
        int               pick;
        int               sub;
        int               r0;
        int               c0;
        int               r1;
        int               c1;
        int               bidx;
        logic [CMD_W-1:0] code;
        pick = $urandom_range(0, 99);
        r0   = $urandom_range(0, 255);
        c0   = $urandom_range(0, 255);
        r1   = $urandom_range(0, 255);
        c1   = $urandom_range(0, 255);
        bidx = $urandom_range(0, 2047);
        if (pick < 2)
            code = CMD_CLEAR;
        else if (pick < 4)
            code = CMD_SPARE;
        else if (pick < 42)
        begin
            code = CMD_READ;
            sub  = $urandom_range(0, 9);
            if (sub >= 5)
                bidx = (layout_now == LAYOUT_PAGE) ? (hot_row >> 3) * SCREEN_W + hot_col
                                                   : (hot_row * SCREEN_W + hot_col) >> 3;
            else if (sub >= 1)
                bidx = $urandom_range(0, STORE_BYTES - 1);
        end
        else
        begin
            code = CMD_FILL;
            if (pick < 96)
            begin
                r0 = $urandom_range(0, SCREEN_H + 6);
                c0 = $urandom_range(0, SCREEN_W + 8);
                r1 = r0 + $urandom_range(0, 10);
                c1 = c0 + $urandom_range(0, 20);
            end
            else if (pick >= 98)
            begin
                r0 = $urandom_range(0, 8);
                c0 = $urandom_range(0, 16);
                r1 = $urandom_range(SCREEN_H - 8, 255);
                c1 = $urandom_range(SCREEN_W - 16, 255);
            end
            // later reads aim at the top-left pixel of the last visible rectangle
            if (r0 < SCREEN_H && c0 < SCREEN_W && r0 <= r1 && c0 <= c1)
            begin
                hot_row = r0;
                hot_col = c0;
            end
        end
        send_cmd(code, r0, c0, r1, c1, bidx);
    endtask

    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_CLEAR;
        cmd_ch.row_first  <= '0;
        cmd_ch.col_first  <= '0;
        cmd_ch.row_last   <= '0;
        cmd_ch.col_last   <= '0;
        cmd_ch.byte_index <= '0;
        layout_now         = LAYOUT_LINEAR;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // same as the reset value, so harmless while the store is still being zeroed
        set_layout(LAYOUT_LINEAR);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                set_layout((phase % 2 == 1) ? LAYOUT_PAGE : LAYOUT_LINEAR);
            end
            if (phase < 2)
                directed_items();
            repeat (RANDOM_PER_PHASE) random_item();
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d clears, %0d fills, %0d reads and %0d unused codes over %0d layout phases",
                 n_clear, n_fill, n_read, n_spare, PHASES);
        $display("Compared %0d result bytes, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Timed out with %0d results outstanding", in_flight);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
